// ===== hw/rtl/gbi_pkg.sv =====
`default_nettype none

package gbi_pkg;

    localparam int NUM_PINS   = 94;
    localparam int NUM_BANKS  = 3;
    localparam int BANK_BITS  = NUM_BANKS * 32;
    localparam int PIN_FIELD_W = 7;
    localparam int PIN_W      = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;
    localparam int ENTRY_W    = 34;

    localparam logic [BANK_BITS-1:0] PIN_MASK =
        {BANK_BITS{1'b1}} >> (BANK_BITS - NUM_PINS);

    localparam logic [9:0] ADDR_GLOBAL = 10'h07C;
    localparam logic [9:0] ADDR_STATUS = 10'h080;
    localparam logic [9:0] ADDR_ENABLE = 10'h090;
    localparam logic [9:0] ADDR_CONF1  = 10'h100;
    localparam logic [9:0] ADDR_CONF2  = 10'h104;

    localparam int BIT_OUT_LVL = 31;
    localparam int BIT_IN_LVL  = 30;
    localparam int BIT_TRIG    = 4;
    localparam int BIT_INV     = 3;
    localparam int BIT_DIR     = 2;
    localparam int BIT_GPIO    = 0;
    localparam int BIT_INDIS   = 2;

    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_EVENT = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        CFG_OWNED_LOW  = 2'd0,
        CFG_OWNED_MID  = 2'd1,
        CFG_OWNED_HIGH = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [1:0]             action;
        logic [9:0]             address;
        logic [31:0]            write_data;
        logic [PIN_FIELD_W-1:0] pin_index;
        logic                   pin_level;
    } item_t;

    typedef struct packed {
        logic [31:0]            read_data;
        logic                   irq_line;
        logic [PIN_FIELD_W-1:0] drive_pin;
        logic                   drive_enable;
        logic                   drive_level;
    } result_t;

    typedef struct packed {
        logic                   named;
        logic [PIN_FIELD_W-1:0] pin;
    } pin_ref_t;

    typedef struct packed {
        logic             fire;
        logic             read_en;
        logic [PIN_W-1:0] read_idx;
    } step_t;

    // Resolves the pin an item refers to, either through a pin register
    // address or through a level event.
    function automatic pin_ref_t item_pin(item_t it);
        pin_ref_t               r;
        logic [PIN_FIELD_W-1:0] conf_pin;
        logic                   is_bus;
        conf_pin = it.address[9:3] - ADDR_CONF1[9:3];
        is_bus   = (it.action == ACT_READ) || (it.action == ACT_WRITE);
        r.named  = 1'b0;
        r.pin    = '0;
        if (is_bus && (it.address[9:8] != 2'd0)
            && (conf_pin < PIN_FIELD_W'(NUM_PINS))) begin
            r.named = 1'b1;
            r.pin   = conf_pin;
        end else if ((it.action == ACT_EVENT)
                     && (it.pin_index < PIN_FIELD_W'(NUM_PINS))) begin
            r.named = 1'b1;
            r.pin   = it.pin_index;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gbi_if.sv =====
`default_nettype none

interface gbi_item_if;
    logic           valid;
    logic           ready;
    gbi_pkg::item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface gbi_result_if;
    logic             valid;
    logic             ready;
    gbi_pkg::result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface gbi_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/gbi_pin_ram.sv =====
`default_nettype none

module gbi_pin_ram (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          wr_en,
    input  wire logic [gbi_pkg::PIN_W-1:0]     wr_idx,
    input  wire logic [gbi_pkg::ENTRY_W-1:0]   wr_data,
    input  wire logic                          rd_en,
    input  wire logic [gbi_pkg::PIN_W-1:0]     rd_idx,
    output logic      [gbi_pkg::ENTRY_W-1:0]   rd_data
);
    import gbi_pkg::*;

    logic [ENTRY_W-1:0]  mem [NUM_PINS];
    logic [NUM_PINS-1:0] vld_reg;
    logic [ENTRY_W-1:0]  rd_data_reg;

    // Entries never written read as their reset value of zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr_en)
        begin
            vld_reg[wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            if (wr_en && (wr_idx == rd_idx))
            begin
                rd_data_reg <= wr_data;
            end
            else if (vld_reg[rd_idx])
            begin
                rd_data_reg <= mem[rd_idx];
            end
            else
            begin
                rd_data_reg <= '0;
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/gbi_regfile.sv =====
`default_nettype none

module gbi_regfile (
    input  wire logic             clk,
    input  wire logic             rst_n,
    gbi_cfg_if.sink               cfg,
    input  wire gbi_pkg::step_t   step,
    input  wire gbi_pkg::item_t   item,
    output gbi_pkg::result_t      result
);
    import gbi_pkg::*;

    logic [31:0] owned_low_reg;
    logic [31:0] owned_mid_reg;
    logic [29:0] owned_high_reg;
    logic [31:0] global_reg;
    logic [31:0] global_next;
    logic [BANK_BITS-1:0] status_reg;
    logic [BANK_BITS-1:0] status_next;
    logic [BANK_BITS-1:0] enable_reg;
    logic [BANK_BITS-1:0] enable_next;
    logic [NUM_PINS-1:0] gpio_reg;
    logic [NUM_PINS-1:0] gpio_next;
    logic [NUM_PINS-1:0] dir_reg;
    logic [NUM_PINS-1:0] dir_next;
    logic [NUM_PINS-1:0] trig_reg;
    logic [NUM_PINS-1:0] trig_next;
    logic [NUM_PINS-1:0] inv_reg;
    logic [NUM_PINS-1:0] inv_next;
    logic [NUM_PINS-1:0] out_reg;
    logic [NUM_PINS-1:0] out_next;
    logic [NUM_PINS-1:0] indis_reg;
    logic [NUM_PINS-1:0] indis_next;
    logic [NUM_PINS-1:0] sensed_reg;
    logic [NUM_PINS-1:0] sensed_next;

    logic                ram_we;
    logic [ENTRY_W-1:0]  ram_wd;
    logic [ENTRY_W-1:0]  ram_rd;

    pin_ref_t    pref;
    logic [PIN_W-1:0] pidx;
    logic [1:0]  bank;
    logic        is_bus;
    logic        is_wr;
    logic        own_hit;
    logic        glob_hit;
    logic        stat_hit;
    logic        en_hit;
    logic        conf_hit;
    logic [31:0] rd;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owned_low_reg  <= '1;
            owned_mid_reg  <= '1;
            owned_high_reg <= '1;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_OWNED_LOW:  owned_low_reg  <= cfg.data;
                CFG_OWNED_MID:  owned_mid_reg  <= cfg.data;
                CFG_OWNED_HIGH: owned_high_reg <= cfg.data[29:0];
                default:        ;
            endcase
        end
    end

    gbi_pin_ram u_pin_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (ram_we),
        .wr_idx  (pidx),
        .wr_data (ram_wd),
        .rd_en   (step.read_en),
        .rd_idx  (step.read_idx),
        .rd_data (ram_rd)
    );

    always_comb
    begin
        pref     = item_pin(item);
        pidx     = pref.named ? pref.pin[PIN_W-1:0] : '0;
        bank     = item.address[3:2];
        is_bus   = (item.action == ACT_READ) || (item.action == ACT_WRITE);
        is_wr    = (item.action == ACT_WRITE);
        own_hit  = (item.address[9:4] == 6'd0) && (bank != 2'd3);
        glob_hit = (item.address[9:2] == ADDR_GLOBAL[9:2]);
        stat_hit = (item.address[9:4] == ADDR_STATUS[9:4]) && (bank != 2'd3);
        en_hit   = (item.address[9:4] == ADDR_ENABLE[9:4]) && (bank != 2'd3);
        conf_hit = is_bus && pref.named;

        global_next = global_reg;
        status_next = status_reg;
        enable_next = enable_reg;
        gpio_next   = gpio_reg;
        dir_next    = dir_reg;
        trig_next   = trig_reg;
        inv_next    = inv_reg;
        out_next    = out_reg;
        indis_next  = indis_reg;
        sensed_next = sensed_reg;
        ram_we      = 1'b0;
        ram_wd      = ram_rd;
        rd          = '0;

        if (is_bus)
        begin
            if (own_hit)
            begin
                case (bank)
                    2'd0:    rd = owned_low_reg;
                    2'd1:    rd = owned_mid_reg;
                    2'd2:    rd = {2'b00, owned_high_reg};
                    default: rd = '0;
                endcase
            end
            else if (glob_hit)
            begin
                rd = global_reg;
                if (is_wr)
                begin
                    global_next = item.write_data;
                end
            end
            else if (stat_hit)
            begin
                rd = status_reg[32*bank +: 32];
                if (is_wr)
                begin
                    status_next[32*bank +: 32] = status_reg[32*bank +: 32] & ~item.write_data;
                end
            end
            else if (en_hit)
            begin
                rd = enable_reg[32*bank +: 32];
                if (is_wr)
                begin
                    enable_next[32*bank +: 32] = item.write_data & PIN_MASK[32*bank +: 32];
                end
            end
            else if (conf_hit)
            begin
                if (!item.address[2])
                begin
                    rd = ram_rd[31:0];
                    rd[BIT_IN_LVL] = sensed_reg[pidx];
                    if (is_wr)
                    begin
                        ram_we = step.fire;
                        ram_wd = {ram_rd[33:32], item.write_data};
                        ram_wd[BIT_IN_LVL] = 1'b0;
                        gpio_next[pidx] = item.write_data[BIT_GPIO];
                        dir_next[pidx]  = item.write_data[BIT_DIR];
                        trig_next[pidx] = item.write_data[BIT_TRIG];
                        inv_next[pidx]  = item.write_data[BIT_INV];
                        out_next[pidx]  = item.write_data[BIT_OUT_LVL];
                    end
                end
                else
                begin
                    rd = {29'd0, indis_reg[pidx], ram_rd[33:32]};
                    if (is_wr)
                    begin
                        ram_we = step.fire;
                        ram_wd = {item.write_data[1:0], ram_rd[31:0]};
                        indis_next[pidx] = item.write_data[BIT_INDIS];
                    end
                end
            end
            if (is_wr)
            begin
                rd = '0;
            end
        end
        else if ((item.action == ACT_EVENT) && pref.named)
        begin
            sensed_next[pidx] = item.pin_level;
            if (gpio_reg[pidx] && dir_reg[pidx] && !indis_reg[pidx] && !trig_reg[pidx]
                && (sensed_reg[pidx] != item.pin_level)
                && (item.pin_level != inv_reg[pidx]))
            begin
                status_next[pidx] = 1'b1;
            end
        end

        // Level-triggered pins keep their status set for as long as the level holds.
        for (int p = 0; p < NUM_PINS; p++)
        begin
            if (gpio_next[p] && dir_next[p] && !indis_next[p] && trig_next[p]
                && (sensed_next[p] == inv_next[p]))
            begin
                status_next[p] = 1'b1;
            end
        end

        result.read_data    = rd;
        result.irq_line     = |(status_next & enable_next);
        result.drive_pin    = pref.named ? pref.pin : '0;
        result.drive_enable = pref.named && gpio_next[pidx] && !dir_next[pidx];
        result.drive_level  = pref.named && out_next[pidx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            global_reg <= '0;
            status_reg <= '0;
            enable_reg <= '0;
            gpio_reg   <= '0;
            dir_reg    <= '0;
            trig_reg   <= '0;
            inv_reg    <= '0;
            out_reg    <= '0;
            indis_reg  <= '1;
            sensed_reg <= '0;
        end
        else if (step.fire)
        begin
            global_reg <= global_next;
            status_reg <= status_next;
            enable_reg <= enable_next;
            gpio_reg   <= gpio_next;
            dir_reg    <= dir_next;
            trig_reg   <= trig_next;
            inv_reg    <= inv_next;
            out_reg    <= out_next;
            indis_reg  <= indis_next;
            sensed_reg <= sensed_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/gpio_bank_with_interrupts_core.sv =====
// GPIO bank register block with per-pin edge and level interrupts.
// The req channel carries one word per bus read, bus write or pin level
// event; the rsp channel returns exactly one word per request, in order,
// with the read data, the interrupt line and the drive state of the pin
// that the request names. The cfg channel writes the three ownership
// bitmaps and is always ready; it is meant to be used while the block is idle.
// A request is taken into an input register, where the pin register memory
// is also read, and its result is computed and stored in the output
// register. One request is accepted every cycle while rsp is not stalled;
// the single read port of the pin register memory, which bypasses a write
// to the same pin from the request ahead, sets that rate.
// When rsp is stalled, the output register holds its word, the request in
// the input register waits, and req drops ready once both are full.
// Reset clears all interrupt, control and pin state but sets the input-disable
// bits and ownership bitmaps to all ones, at once; there is no clearing pass.
`default_nettype none

module gpio_bank_with_interrupts_core (
    input  wire logic  clk,
    input  wire logic  rst_n,
    gbi_item_if.sink   req,
    gbi_result_if.source rsp,
    gbi_cfg_if.sink    cfg
);
    import gbi_pkg::*;

    logic     s1_valid_reg;
    item_t    s1_item_reg;
    logic     res_valid_reg;
    result_t  res_reg;
    logic     accept;
    logic     s1_fire;
    pin_ref_t in_pin;
    step_t    step;
    result_t  result;

    assign s1_fire   = s1_valid_reg && (!res_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_fire;
    assign accept    = req.valid && req.ready;
    assign in_pin    = item_pin(req.data);

    always_comb
    begin
        step.fire     = s1_fire;
        step.read_en  = accept && in_pin.named;
        step.read_idx = in_pin.pin[PIN_W-1:0];
    end

    gbi_regfile u_regfile (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .step   (step),
        .item   (s1_item_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= req.data;
        end
        if (s1_fire)
        begin
            res_reg <= result;
        end
    end

    assign rsp.valid = res_valid_reg;
    assign rsp.data  = res_reg;

endmodule

`default_nettype wire

// ===== sim/gpio_bank_with_interrupts_core_tb.sv =====
`timescale 1ns / 100ps

module gpio_bank_with_interrupts_core_tb;
    import gbi_pkg::*;

    localparam logic [1:0] ACT_SPARE    = 2'd3;
    localparam logic [1:0] CFG_SPARE    = 2'd3;
    localparam logic [9:0] ADDR_OWNED   = 10'h000;
    localparam int         CONF_STRIDE  = 8;
    localparam int         RANDOM_ITEMS = 250;
    localparam int         DRAIN_CYCLES = 4;
    localparam int         STALL_LIMIT  = 2000;

    class bank_scoreboard;
        logic [31:0] conf_word [NUM_PINS];
        logic [2:0]  aux [NUM_PINS];
        logic        sensed [NUM_PINS];
        logic [31:0] status_bank [NUM_BANKS];
        logic [31:0] enable_bank [NUM_BANKS];
        logic [31:0] owner_map [NUM_BANKS];
        logic [31:0] global_word;
        result_t     due_results [$];
        int          errors;

        function new();
            for (int p = 0; p < NUM_PINS; p++)
            begin
                conf_word[p] = '0;
                aux[p] = '0;
                aux[p][BIT_INDIS] = 1'b1;
                sensed[p] = 1'b0;
            end
            for (int b = 0; b < NUM_BANKS; b++)
            begin
                status_bank[b] = '0;
                enable_bank[b] = '0;
            end
            owner_map[0] = '1;
            owner_map[1] = '1;
            owner_map[2] = {2'b00, {30{1'b1}}};
            global_word = '0;
            errors = 0;
        endfunction

        function logic [31:0] live_bits(int b);
            logic [31:0] m;
            for (int i = 0; i < 32; i++)
                m[i] = (b * 32 + i < NUM_PINS);
            return m;
        endfunction

        function bit senses(int p);
            return conf_word[p][BIT_GPIO] && conf_word[p][BIT_DIR] && !aux[p][BIT_INDIS];
        endfunction

        function void load_owner_map(logic [1:0] index, logic [31:0] value);
            case (index)
                CFG_OWNED_LOW:  owner_map[0] = value;
                CFG_OWNED_MID:  owner_map[1] = value;
                CFG_OWNED_HIGH: owner_map[2] = {2'b00, value[29:0]};
                default:        ;
            endcase
        endfunction

        function void note_request(item_t it);
            logic [9:0]  a;
            logic [31:0] rd;
            logic [31:0] raised;
            logic        old_level;
            bit          named;
            bit          wr;
            int          pin;
            int          p;
            int          b;
            result_t     want;
            a = {it.address[9:2], 2'b00};
            rd = '0;
            raised = '0;
            named = 1'b0;
            pin = 0;
            if (it.action == ACT_READ || it.action == ACT_WRITE)
            begin
                wr = (it.action == ACT_WRITE);
                if (a < ADDR_OWNED + 4 * NUM_BANKS)
                begin
                    rd = owner_map[a[3:2]];
                end
                else if (a == ADDR_GLOBAL)
                begin
                    rd = global_word;
                    if (wr)
                        global_word = it.write_data;
                end
                else if (a >= ADDR_STATUS && a < ADDR_STATUS + 4 * NUM_BANKS)
                begin
                    b = (a - ADDR_STATUS) >> 2;
                    rd = status_bank[b];
                    if (wr)
                        status_bank[b] &= ~it.write_data;
                end
                else if (a >= ADDR_ENABLE && a < ADDR_ENABLE + 4 * NUM_BANKS)
                begin
                    b = (a - ADDR_ENABLE) >> 2;
                    rd = enable_bank[b];
                    if (wr)
                        enable_bank[b] = it.write_data & live_bits(b);
                end
                else if (a >= ADDR_CONF1)
                begin
                    p = (a - ADDR_CONF1) / CONF_STRIDE;
                    if (p < NUM_PINS)
                    begin
                        named = 1'b1;
                        pin = p;
                        if (!a[2])
                        begin
                            rd = conf_word[p];
                            rd[BIT_IN_LVL] = sensed[p];
                            if (wr)
                            begin
                                conf_word[p] = it.write_data;
                                conf_word[p][BIT_IN_LVL] = 1'b0;
                            end
                        end
                        else
                        begin
                            rd = {29'd0, aux[p]};
                            if (wr)
                                aux[p] = it.write_data[2:0];
                        end
                    end
                end
                if (wr)
                    rd = '0;
            end
            else if (it.action == ACT_EVENT && it.pin_index < NUM_PINS)
            begin
                named = 1'b1;
                pin = it.pin_index;
                old_level = sensed[pin];
                sensed[pin] = it.pin_level;
                if (senses(pin) && !conf_word[pin][BIT_TRIG] && old_level != it.pin_level
                    && it.pin_level != conf_word[pin][BIT_INV])
                    status_bank[pin / 32][pin % 32] = 1'b1;
            end
            // Level-triggered pins reassert their status at the end of every word.
            for (p = 0; p < NUM_PINS; p++)
            begin
                if (senses(p) && conf_word[p][BIT_TRIG] && sensed[p] == conf_word[p][BIT_INV])
                    status_bank[p / 32][p % 32] = 1'b1;
            end
            for (b = 0; b < NUM_BANKS; b++)
                raised |= status_bank[b] & enable_bank[b];
            want.read_data = rd;
            want.irq_line = |raised;
            want.drive_pin = named ? 7'(pin) : '0;
            want.drive_enable = named && conf_word[pin][BIT_GPIO] && !conf_word[pin][BIT_DIR];
            want.drive_level = named && conf_word[pin][BIT_OUT_LVL];
            due_results.push_back(want);
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected %h, got %h", field, want, got);
                errors++;
            end
        endfunction

        function void check_response(result_t got);
            result_t want;
            if (due_results.size() == 0)
            begin
                $error("response word with nothing pending: %h", got);
                errors++;
                return;
            end
            want = due_results.pop_front();
            compare("read_data", want.read_data, got.read_data);
            compare("irq_line", want.irq_line, got.irq_line);
            compare("drive_pin", want.drive_pin, got.drive_pin);
            compare("drive_enable", want.drive_enable, got.drive_enable);
            compare("drive_level", want.drive_level, got.drive_level);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_stall_pct;

    bank_scoreboard sb = new();

    gbi_item_if   req_if ();
    gbi_result_if rsp_if ();
    gbi_cfg_if    cfg_if ();

    gpio_bank_with_interrupts_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int hot_pin();
        case ($urandom_range(7))
            0:       return 0;
            1:       return 5;
            2:       return 31;
            3:       return 32;
            4:       return 47;
            5:       return 63;
            6:       return 64;
            default: return NUM_PINS - 1;
        endcase
    endfunction

    // Most words target a few pins so that they get configured to sense and then see events.
    function automatic item_t random_item();
        item_t it;
        int    sel;
        int    pin;
        int    bank;
        it.action = ACT_READ;
        it.address = 10'($urandom_range(1023));
        it.write_data = $urandom();
        it.pin_index = 7'($urandom_range(127));
        it.pin_level = 1'($urandom_range(1));
        sel = $urandom_range(99);
        pin = ($urandom_range(4) == 0) ? $urandom_range(95) : hot_pin();
        bank = $urandom_range(NUM_BANKS - 1);
        if (sel < 30)
        begin
            it.action = ACT_EVENT;
            if ($urandom_range(9) != 0)
                it.pin_index = 7'(hot_pin());
        end
        else if (sel < 50)
        begin
            it.action = ACT_WRITE;
            it.address = ADDR_CONF1 + 10'(CONF_STRIDE * pin);
            it.write_data[BIT_GPIO] = ($urandom_range(9) < 8);
            it.write_data[BIT_DIR] = ($urandom_range(9) < 7);
        end
        else if (sel < 58)
        begin
            it.action = ACT_WRITE;
            it.address = ADDR_CONF2 + 10'(CONF_STRIDE * pin);
            it.write_data[BIT_INDIS] = ($urandom_range(9) < 3);
        end
        else if (sel < 70)
        begin
            it.action = ACT_WRITE;
            case ($urandom_range(3))
                0: it.address = ADDR_STATUS + 10'(4 * bank);
                1:
                begin
                    it.address = ADDR_ENABLE + 10'(4 * bank);
                    if ($urandom_range(1))
                        it.write_data = '1;
                end
                2: it.address = ADDR_GLOBAL;
                default: it.address = ADDR_OWNED + 10'(4 * bank);
            endcase
        end
        else if (sel < 95)
        begin
            case ($urandom_range(3))
                0: it.address = ADDR_STATUS + 10'(4 * bank);
                1: it.address = ADDR_ENABLE + 10'(4 * bank);
                2: it.address = ADDR_CONF1 + 10'(CONF_STRIDE * pin);
                default: ;
            endcase
        end
        else
        begin
            it.action = $urandom_range(1) ? ACT_SPARE : ACT_WRITE;
        end
        if (it.action != ACT_EVENT)
            it.address[1:0] = 2'($urandom_range(3));
        return it;
    endfunction

    task automatic send_item(input item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= it;
        do
            @(posedge clk);
        while (!req_if.ready);
        sb.note_request(it);
    endtask

    task automatic set_owner_maps(input logic [31:0] low, input logic [31:0] mid,
                                  input logic [31:0] high);
        logic [1:0]  regs [4];
        logic [31:0] values [4];
        regs = '{CFG_OWNED_LOW, CFG_OWNED_MID, CFG_OWNED_HIGH, CFG_SPARE};
        values = '{low, mid, high, $urandom()};
        for (int i = 0; i < 4; i++)
        begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= regs[i];
            cfg_if.data  <= values[i];
            do
                @(posedge clk);
            while (!cfg_if.ready);
            sb.load_owner_map(regs[i], values[i]);
        end
        cfg_if.valid <= 1'b0;
    endtask

    task automatic finish_phase();
        req_if.valid <= 1'b0;
        while (sb.due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_if.valid && rsp_if.ready)
                sb.check_response(rsp_if.data);
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        int idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
                || (cfg_if.valid && cfg_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        item_t directed [$];
        rst_n <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.data <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= CFG_OWNED_LOW;
        cfg_if.data <= '0;
        send_idle_pct = 37;
        recv_stall_pct = 88;

        directed.push_back(item_t'{ACT_READ, ADDR_OWNED, 32'h0, 7'd0, 1'b0});
        directed.push_back(item_t'{ACT_READ, ADDR_OWNED + 10'd7, 32'h0, 7'd0, 1'b0});
        directed.push_back(item_t'{ACT_READ, ADDR_OWNED + 10'd8, 32'h0, 7'd0, 1'b0});
        directed.push_back(item_t'{ACT_READ, ADDR_OWNED + 10'd12, 32'h0, 7'd0, 1'b0});
        directed.push_back(item_t'{ACT_WRITE, ADDR_OWNED, 32'h0, 7'd0, 1'b0});
        directed.push_back(item_t'{ACT_READ, ADDR_OWNED, 32'h0, 7'd0, 1'b0});
        directed.push_back(item_t'{ACT_WRITE, ADDR_GLOBAL, 32'hFFFF_FFFF, 7'd0, 1'b0});
        directed.push_back(item_t'{ACT_READ, ADDR_GLOBAL + 10'd1, 32'h0, 7'd0, 1'b0});
        directed.push_back(item_t'{ACT_WRITE, ADDR_ENABLE + 10'd8, 32'hFFFF_FFFF, 7'd0, 1'b0});
        directed.push_back(item_t'{ACT_READ, ADDR_ENABLE + 10'd8, 32'h0, 7'd0, 1'b0});
        directed.push_back(item_t'{ACT_WRITE, ADDR_ENABLE, 32'hFFFF_FFFF, 7'd0, 1'b0});
        directed.push_back(item_t'{ACT_WRITE, ADDR_CONF1, 32'h8000_0001, 7'd0, 1'b0});
        directed.push_back(item_t'{ACT_READ, ADDR_CONF1, 32'h0, 7'd0, 1'b0});
        directed.push_back(item_t'{ACT_WRITE, ADDR_CONF1 + 10'(CONF_STRIDE * 5), 32'h5,
                                   7'd0, 1'b0});
        directed.push_back(item_t'{ACT_WRITE, ADDR_CONF2 + 10'(CONF_STRIDE * 5), 32'h3,
                                   7'd0, 1'b0});
        directed.push_back(item_t'{ACT_EVENT, 10'h0, 32'h0, 7'd5, 1'b1});
        directed.push_back(item_t'{ACT_READ, ADDR_STATUS, 32'h0, 7'd0, 1'b0});
        directed.push_back(item_t'{ACT_WRITE, ADDR_STATUS, 32'h20, 7'd0, 1'b0});
        directed.push_back(item_t'{ACT_WRITE, ADDR_CONF1 + 10'(CONF_STRIDE * 93), 32'h1D,
                                   7'd0, 1'b0});
        directed.push_back(item_t'{ACT_WRITE, ADDR_CONF2 + 10'(CONF_STRIDE * 93), 32'h0,
                                   7'd0, 1'b0});
        directed.push_back(item_t'{ACT_EVENT, 10'h0, 32'h0, 7'd93, 1'b1});
        directed.push_back(item_t'{ACT_WRITE, ADDR_STATUS + 10'd8, 32'hFFFF_FFFF, 7'd0, 1'b0});
        directed.push_back(item_t'{ACT_READ, ADDR_CONF1 + 10'(CONF_STRIDE * 93), 32'h0,
                                   7'd0, 1'b0});
        directed.push_back(item_t'{ACT_EVENT, 10'h0, 32'h0, 7'd127, 1'b1});
        directed.push_back(item_t'{ACT_READ, ADDR_CONF1 + 10'(CONF_STRIDE * NUM_PINS), 32'h0,
                                   7'd0, 1'b0});
        directed.push_back(item_t'{ACT_SPARE, 10'h3FF, 32'hFFFF_FFFF, 7'd127, 1'b1});

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            send_item(directed[i]);
        finish_phase();

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0: set_owner_maps('0, $urandom(), '1);
                1:
                begin
                    send_idle_pct = 88;
                    recv_stall_pct = 37;
                    set_owner_maps($urandom(), $urandom(), $urandom());
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                    set_owner_maps('1, '0, '0);
                end
            endcase
            repeat (RANDOM_ITEMS) send_item(random_item());
            finish_phase();
        end

        if (sb.errors == 0 && sb.due_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
